[rtl/core/servo_frame_receiver_core_defines.svh]
// assertion macros for the servo frame receiver core
// used by modules that carry concurrent checks; expects i_clk and i_rst_n in scope
`ifndef SERVO_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SERVO_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sfr_pkg.sv]
// shared types, codes and constants of the servo frame receiver
// no dependencies
package sfr_pkg;

    localparam int MAX_FRAME_DEFAULT = 32;

    // input item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CHECKSUM  = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_ID = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_HEADER_WORD   = 2'd0;
    localparam logic [1:0] CFG_MAX_NODE_ID   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [15:0] HEADER_WORD_RST   = 16'hFFFF;
    localparam logic [7:0]  MAX_NODE_ID_RST   = 8'd253;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_sfr_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] node_id;
        logic [7:0] frame_size;
        logic [7:0] status_byte;
        logic [7:0] content_byte;
        logic [4:0] content_index;
        logic       last;
    } t_sfr_out;

    typedef struct packed {
        logic [15:0] header_word;
        logic [7:0]  max_node_id;
        logic [15:0] timeout_ticks;
    } t_sfr_cfg;

    // result request from the parser to the emitter
    typedef struct packed {
        logic       valid;
        logic       burst;   // play back stored content instead of one result
        logic [2:0] status;
        logic [7:0] node_id;
        logic [7:0] frame_size;
        logic [7:0] status_byte;
    } t_sfr_cmd;

endpackage

[rtl/core/sfr_content_ram.sv]
// content byte store: one write port, one read port with registered data
// depends on the store depth handed down from the top level
module sfr_content_ram #(
    parameter int DEPTH = 25,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sfr_parser.sv]
// frame state machine: header hunt, field capture, checksum, timeout
// depends on sfr_pkg; writes content bytes into sfr_content_ram
module sfr_parser #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEFAULT,
    parameter int CW        = 5,
    parameter int AW        = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sfr_pkg::t_sfr_in  i_item,
    input  sfr_pkg::t_sfr_cfg i_cfg,
    output sfr_pkg::t_sfr_cmd o_cmd,
    output logic [CW-1:0]     o_count,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [7:0]        o_wdata
);
    import sfr_pkg::*;

    localparam int STORE_DEPTH = MAX_FRAME - 7;
    localparam int SIZE_LIMIT  = MAX_FRAME - 5;

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_ID   = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_STAT = 6'b001000,
        PH_DATA = 6'b010000,
        PH_SUM  = 6'b100000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic          r_got_first, n_got_first;
    logic [7:0]    r_frame_id, n_frame_id;
    logic [7:0]    r_frame_len, n_frame_len;
    logic [7:0]    r_frame_stat, n_frame_stat;
    logic [7:0]    r_sum, n_sum;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_ticks, n_ticks;

    logic          do_clear;
    logic [7:0]    b;
    logic [15:0]   ticks_inc;
    logic [CW-1:0] count_inc;
    t_sfr_cmd      cmd;

    assign b         = i_item.rx_byte;
    assign ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign count_inc = r_count + CW'(1);

    always_comb begin
        n_phase      = r_phase;
        n_got_first  = r_got_first;
        n_frame_id   = r_frame_id;
        n_frame_len  = r_frame_len;
        n_frame_stat = r_frame_stat;
        n_sum        = r_sum;
        n_count      = r_count;
        n_ticks      = r_ticks;
        do_clear     = 1'b0;
        o_we         = 1'b0;
        cmd          = '0;
        cmd.node_id     = r_frame_id;
        cmd.frame_size  = r_frame_len;
        cmd.status_byte = r_frame_stat;

        if (i_accept) begin
            if (i_item.req_type == REQ_TICK) begin
                if (!(r_phase == PH_HUNT && !r_got_first)) begin
                    n_ticks = ticks_inc;
                    if (ticks_inc >= i_cfg.timeout_ticks) begin
                        cmd.valid  = 1'b1;
                        cmd.status = ST_TIMEOUT;
                        do_clear   = 1'b1;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (!r_got_first) begin
                            if (b == i_cfg.header_word[7:0]) begin
                                n_got_first = 1'b1;
                                n_ticks     = 16'd0;
                            end
                        end else if (b == i_cfg.header_word[15:8]) begin
                            n_got_first = 1'b0;
                            n_phase     = PH_ID;
                        end else begin
                            do_clear = 1'b1;
                        end
                    end
                    PH_ID: begin
                        n_frame_id  = b;
                        cmd.node_id = b;
                        if (b > i_cfg.max_node_id) begin
                            cmd.valid  = 1'b1;
                            cmd.status = ST_UNKNOWN_ID;
                            do_clear   = 1'b1;
                        end else begin
                            n_sum   = b;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_frame_len    = b;
                        cmd.frame_size = b;
                        if (b > 8'(SIZE_LIMIT) || b < 8'd2) begin
                            cmd.valid  = 1'b1;
                            cmd.status = ST_BAD_SIZE;
                            do_clear   = 1'b1;
                        end else begin
                            n_sum   = r_sum + b;
                            n_phase = PH_STAT;
                        end
                    end
                    PH_STAT: begin
                        n_frame_stat = b;
                        n_sum        = r_sum + b;
                        n_count      = '0;
                        n_phase      = (r_frame_len == 8'd2) ? PH_SUM : PH_DATA;
                    end
                    PH_DATA: begin
                        o_we    = (r_count < CW'(STORE_DEPTH));
                        n_count = count_inc;
                        n_sum   = r_sum + b;
                        // length is at least three here, so length-2 stays positive
                        if (9'(count_inc) >= ({1'b0, r_frame_len} - 9'd2)) begin
                            n_phase = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        cmd.valid = 1'b1;
                        if (b != ~r_sum) begin
                            cmd.status = ST_CHECKSUM;
                        end else begin
                            cmd.status = ST_OK;
                            cmd.burst  = (r_count != '0);
                        end
                        do_clear = 1'b1;
                    end
                    default: begin
                        do_clear = 1'b1;
                    end
                endcase
            end
        end

        if (do_clear) begin
            n_phase      = PH_HUNT;
            n_got_first  = 1'b0;
            n_frame_id   = 8'd0;
            n_frame_len  = 8'd0;
            n_frame_stat = 8'd0;
            n_sum        = 8'd0;
            n_count      = '0;
            n_ticks      = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_got_first  <= 1'b0;
            r_frame_id   <= 8'd0;
            r_frame_len  <= 8'd0;
            r_frame_stat <= 8'd0;
            r_sum        <= 8'd0;
            r_count      <= '0;
            r_ticks      <= 16'd0;
        end else begin
            r_phase      <= n_phase;
            r_got_first  <= n_got_first;
            r_frame_id   <= n_frame_id;
            r_frame_len  <= n_frame_len;
            r_frame_stat <= n_frame_stat;
            r_sum        <= n_sum;
            r_count      <= n_count;
            r_ticks      <= n_ticks;
        end
    end

    assign o_cmd   = cmd;
    assign o_count = r_count;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = b;

endmodule

[rtl/core/sfr_emitter.sv]
// result sequencer and output register: single results and content playback
// depends on sfr_pkg and the assertion macro header; reads sfr_content_ram
`include "servo_frame_receiver_core_defines.svh"
module sfr_emitter #(
    parameter int CW        = 5,
    parameter int AW        = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfr_pkg::t_sfr_cmd i_cmd,
    input  logic [CW-1:0]     i_count,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  logic [7:0]        i_rdata,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sfr_pkg::t_sfr_out o_out_item,
    output logic              o_idle
);
    import sfr_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE   = 4'b0001,
        E_SINGLE = 4'b0010,
        E_READ   = 4'b0100,
        E_PUSH   = 4'b1000
    } t_emit_state;

    t_emit_state   r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_idx, n_idx;
    logic [2:0]    r_status;
    logic [7:0]    r_id, r_len, r_stat;
    logic          r_out_valid, n_out_valid;
    t_sfr_out      r_out, n_out;
    logic          out_free;
    logic          is_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign is_last  = ((r_idx + CW'(1)) == r_n);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_re        = 1'b0;
        unique case (r_state)
            E_IDLE: begin
                if (i_cmd.valid) begin
                    n_n     = i_count;
                    n_idx   = '0;
                    n_state = i_cmd.burst ? E_READ : E_SINGLE;
                end
            end
            E_SINGLE: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.node_id       = r_id;
                    n_out.frame_size    = r_len;
                    n_out.status_byte   = r_stat;
                    n_out.content_byte  = 8'd0;
                    n_out.content_index = 5'd0;
                    n_out.last          = 1'b1;
                    n_state             = E_IDLE;
                end
            end
            E_READ: begin
                o_re    = 1'b1;
                n_state = E_PUSH;
            end
            E_PUSH: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = ST_OK;
                    n_out.node_id       = r_id;
                    n_out.frame_size    = r_len;
                    n_out.status_byte   = r_stat;
                    n_out.content_byte  = i_rdata;
                    n_out.content_index = 5'(r_idx);
                    n_out.last          = is_last;
                    n_idx               = r_idx + CW'(1);
                    n_state             = is_last ? E_IDLE : E_READ;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_idx       <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == E_IDLE && i_cmd.valid) begin
            r_status <= i_cmd.status;
            r_id     <= i_cmd.node_id;
            r_len    <= i_cmd.frame_size;
            r_stat   <= i_cmd.status_byte;
        end
    end

    assign o_raddr     = r_idx[AW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_idle      = (r_state == E_IDLE);

    `SFR_ASSERT_NOW(a_cmd_only_when_idle, i_cmd.valid, r_state == E_IDLE,
        "result request arrived while emitter busy")
    `SFR_ASSERT_NEXT(a_read_then_push, o_re, r_state == E_PUSH,
        "content read not followed by push")
    `SFR_ASSERT_NOW(a_read_in_range, r_state == E_READ, r_idx < r_n,
        "content read past stored count")

endmodule

[rtl/core/servo_frame_receiver_core.sv]
// servo frame receiver: an error, timeout or empty frame result is registered in the
// emitter state and then in the output register; a good frame plays back its content
// results in turn, each a memory read then an output load, and waits while the output
// register is held; input is held off until the last result is in
// the output register; reset is synchronous active low, clears the frame state and
// restores config defaults; the content memory is not cleared and is read only where written
module servo_frame_receiver_core #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input: received bytes and millisecond ticks
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sfr_pkg::t_sfr_in  i_in_item,
    // results
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sfr_pkg::t_sfr_out o_out_item,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import sfr_pkg::*;

    // content memory holds length-2 bytes of the largest legal frame
    localparam int STORE_DEPTH = MAX_FRAME - 7;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_sfr_cfg      r_cfg;
    t_sfr_cmd      cmd;
    logic [CW-1:0] count;
    logic          accept;
    logic          emit_idle;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    // config port always open; user must write with no item in flight; not enforced
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_word   <= HEADER_WORD_RST;
            r_cfg.max_node_id   <= MAX_NODE_ID_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_WORD:   r_cfg.header_word   <= i_cfg_data;
                CFG_MAX_NODE_ID:   r_cfg.max_node_id   <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // one item at a time: the parser takes an item whenever the emitter has no
    // result request in hand; a result waiting in the output register does not block
    assign o_in_ready = emit_idle;
    assign accept     = i_in_valid && o_in_ready;

    sfr_parser #(
        .MAX_FRAME (MAX_FRAME),
        .CW        (CW),
        .AW        (AW)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_cmd   (cmd),
        .o_count (count),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata)
    );

    // writes happen only while receiving content, reads only during playback,
    // so the two ports never touch the same entry in one cycle
    sfr_content_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    sfr_emitter #(
        .CW        (CW),
        .AW        (AW)
    ) u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_count    (count),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .o_idle     (emit_idle)
    );

endmodule

[sim/servo_frame_receiver_checker.sv]
// result checker for the servo frame receiver: mirrors the frame parser, queues the
// results each accepted item should cause and compares every accepted result against them
// depends on sfr_pkg for item types, status codes, register indexes and reset values
module servo_frame_receiver_checker #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  sfr_pkg::t_sfr_in  i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  sfr_pkg::t_sfr_out i_out_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output int                o_mismatches,
    output int                o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int STORE_DEPTH = MAX_FRAME - 7;
    localparam int SIZE_LIMIT  = MAX_FRAME - 5;

    typedef enum logic [2:0] {
        PH_HUNT, PH_ID, PH_LEN, PH_STAT, PH_DATA, PH_SUM
    } t_parse_phase;

    t_sfr_cfg     cfg;
    t_parse_phase phase;
    logic         header_lo_seen;
    logic [7:0]   frame_id;
    logic [7:0]   frame_length;
    logic [7:0]   frame_status;
    logic [7:0]   running_sum;
    logic [7:0]   content_mem [STORE_DEPTH];
    int           content_count;
    logic [15:0]  tick_count;
    t_sfr_out     results_due [$];
    int           mismatches = 0;

    function automatic void clear_frame();
        phase          = PH_HUNT;
        header_lo_seen = 1'b0;
        frame_id       = '0;
        frame_length   = '0;
        frame_status   = '0;
        running_sum    = '0;
        content_count  = 0;
        tick_count     = '0;
    endfunction

    function automatic void queue_result(input logic [2:0] st, input logic [7:0] data,
                                         input logic [4:0] idx, input logic last_mark);
        t_sfr_out r;
        r.status        = st;
        r.node_id       = frame_id;
        r.frame_size    = frame_length;
        r.status_byte   = frame_status;
        r.content_byte  = data;
        r.content_index = idx;
        r.last          = last_mark;
        results_due.push_back(r);
    endfunction

    function automatic void abort_frame(input logic [2:0] st);
        queue_result(st, 8'd0, 5'd0, 1'b1);
        clear_frame();
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic parse_item(input t_sfr_in item);
        logic [7:0] b;
        int         n;
        b = item.rx_byte;
        if (item.req_type == REQ_TICK) begin
            // ticks only count once a first header byte has been seen
            if (phase == PH_HUNT && !header_lo_seen) return;
            if (tick_count != 16'hFFFF) tick_count++;
            if (tick_count >= cfg.timeout_ticks) abort_frame(ST_TIMEOUT);
            return;
        end
        case (phase)
            PH_HUNT: begin
                if (!header_lo_seen) begin
                    if (b == cfg.header_word[7:0]) begin
                        header_lo_seen = 1'b1;
                        tick_count     = '0;
                    end
                end else if (b == cfg.header_word[15:8]) begin
                    header_lo_seen = 1'b0;
                    phase          = PH_ID;
                end else begin
                    clear_frame();
                end
            end
            PH_ID: begin
                frame_id = b;
                if (b > cfg.max_node_id) begin
                    abort_frame(ST_UNKNOWN_ID);
                end else begin
                    running_sum = b;
                    phase       = PH_LEN;
                end
            end
            PH_LEN: begin
                frame_length = b;
                if (b > SIZE_LIMIT || b < 2) begin
                    abort_frame(ST_BAD_SIZE);
                end else begin
                    running_sum += b;
                    phase        = PH_STAT;
                end
            end
            PH_STAT: begin
                frame_status   = b;
                running_sum   += b;
                content_count  = 0;
                phase          = (frame_length == 8'd2) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                if (content_count < STORE_DEPTH) content_mem[content_count] = b;
                content_count++;
                running_sum += b;
                if (content_count >= int'(frame_length) - 2) phase = PH_SUM;
            end
            PH_SUM: begin
                if (b != ~running_sum) begin
                    abort_frame(ST_CHECKSUM);
                end else begin
                    n = (content_count > STORE_DEPTH) ? STORE_DEPTH : content_count;
                    if (n == 0) begin
                        queue_result(ST_OK, 8'd0, 5'd0, 1'b1);
                    end else begin
                        for (int k = 0; k < n; k++)
                            queue_result(ST_OK, content_mem[k], 5'(k), k == n - 1);
                    end
                    clear_frame();
                end
            end
            default: clear_frame();
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_sfr_out want;
        if (!i_rst_n) begin
            cfg.header_word   = HEADER_WORD_RST;
            cfg.max_node_id   = MAX_NODE_ID_RST;
            cfg.timeout_ticks = TIMEOUT_TICKS_RST;
            clear_frame();
            results_due.delete();
        end else begin
            // results never come from an item taken at the same edge, so compare first
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t ns: result %h arrived with nothing expected",
                             $time, i_out_item);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, i_out_item.status);
                    check_field("node_id", want.node_id, i_out_item.node_id);
                    check_field("frame_size", want.frame_size, i_out_item.frame_size);
                    check_field("status_byte", want.status_byte, i_out_item.status_byte);
                    check_field("content_byte", want.content_byte, i_out_item.content_byte);
                    check_field("content_index", want.content_index,
                                i_out_item.content_index);
                    check_field("last", want.last, i_out_item.last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEADER_WORD:   cfg.header_word   = i_cfg_data;
                    CFG_MAX_NODE_ID:   cfg.max_node_id   = i_cfg_data[7:0];
                    CFG_TIMEOUT_TICKS: cfg.timeout_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) parse_item(i_in_item);
        end
        o_mismatches  <= mismatches;
        o_results_due <= results_due.size();
    end

endmodule

[sim/tb_top.sv]
// top of the servo frame receiver testbench: clock, reset, item and config stimulus, verdict
// depends on sfr_pkg, servo_frame_receiver_core and servo_frame_receiver_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int SIZE_LIMIT      = MAX_FRAME_DEFAULT - 5;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;

    // kinds of byte sequences the random part builds
    typedef enum {
        FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_ID, FRAME_BAD_SIZE, FRAME_BAD_HEADER,
        FRAME_STALLED
    } t_frame_kind;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_sfr_in     in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_sfr_out    out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int mismatches;
    int results_due;

    // stimulus side view of the registers, used to build frames that get through
    t_sfr_cfg cfg_shadow;
    bit       sender_idles  = 1'b1;
    bit       ready_idles   = 1'b1;
    bit       hold_off_req  = 1'b0;
    int       bytes_sent    = 0;

    servo_frame_receiver_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    servo_frame_receiver_checker frame_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls, or one long hold-off counted here when asked for
    initial begin : out_ready_driver
        int held;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES) begin
                    @(posedge clk);
                    held++;
                end
            end
            out_ready <= ready_idles ? ($urandom_range(99) >= 20) : 1'b1;
        end
    end

    // ends the run when no channel has moved anything for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** servo_frame_receiver_core: FAILED **");
        $finish;
    end

    // offers one item and returns at the edge that takes it; valid is left high so the
    // next item can follow without a gap
    task automatic send_item(input logic kind, input logic [7:0] b);
        if (sender_idles && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {kind, b};
        // ready only moves on rising edges, so look at it mid-cycle
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_BYTE, b);
        bytes_sent++;
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, 8'($urandom_range(255)));
    endtask

    // sender pause: drop valid, let every expected result out, then allow for any
    // item still in flight that causes no result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers are only written with the block idle
    task automatic set_config(input logic [15:0] header, input logic [7:0] max_id,
                              input logic [15:0] ticks);
        wait_drained();
        write_cfg(CFG_HEADER_WORD, header);
        write_cfg(CFG_MAX_NODE_ID, {8'd0, max_id});
        write_cfg(CFG_TIMEOUT_TICKS, ticks);
        cfg_shadow.header_word   = header;
        cfg_shadow.max_node_id   = max_id;
        cfg_shadow.timeout_ticks = ticks;
    endtask

    // builds a well-formed frame for the current header, then breaks it as the kind asks;
    // expects the parser to be hunting with no header byte seen
    task automatic send_frame(input t_frame_kind kind, input int force_len);
        logic [7:0] q [$];
        logic [7:0] len;
        logic [7:0] sum;
        int         budget;
        if (force_len != 0)
            len = 8'(force_len);
        else if ($urandom_range(99) < 85)
            len = 8'($urandom_range(2, 8));
        else
            len = 8'($urandom_range(9, SIZE_LIMIT));
        q = {cfg_shadow.header_word[7:0], cfg_shadow.header_word[15:8],
             8'($urandom_range(cfg_shadow.max_node_id)), len, 8'($urandom_range(255))};
        sum = q[2] + q[3] + q[4];
        repeat (len - 2) begin
            q.push_back(8'($urandom_range(255)));
            sum += q[$];
        end
        q.push_back(~sum);
        case (kind)
            FRAME_BAD_SUM: q[q.size() - 1] ^= 8'($urandom_range(1, 255));
            FRAME_BAD_ID: begin
                q[2] = 8'($urandom_range(cfg_shadow.max_node_id + 1, 255));
                q = q[0:2];
            end
            FRAME_BAD_SIZE: begin
                // below two or above the size limit, both ends of the byte included
                if ($urandom_range(1) != 0)
                    q[3] = 8'($urandom_range(1));
                else
                    q[3] = 8'($urandom_range(SIZE_LIMIT + 1, 255));
                q = q[0:3];
            end
            FRAME_BAD_HEADER: begin
                q[1] ^= 8'($urandom_range(1, 255));
                q = q[0:1];
            end
            FRAME_STALLED: begin
                // a cut-off frame or plain noise, cleaned up by ticks below
                if ($urandom_range(1) != 0) begin
                    q = q[0:$urandom_range(0, 3)];
                end else begin
                    q.delete();
                    repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
                end
            end
            default: ;
        endcase
        // stray ticks inside the frame, always fewer than the timeout
        if (cfg_shadow.timeout_ticks > 7)
            budget = 6;
        else
            budget = int'(cfg_shadow.timeout_ticks) - 1;
        foreach (q[i]) begin
            if (i > 0 && budget > 0 && $urandom_range(99) < 15) begin
                send_tick();
                budget--;
            end
            send_byte(q[i]);
        end
        // enough ticks to time out whatever state the parser was left in
        if (kind == FRAME_STALLED) repeat (cfg_shadow.timeout_ticks) send_tick();
    endtask

    // mostly good frames with random content, the rest broken or noise
    task automatic run_frames(input int goal);
        int          first;
        int          pick;
        t_frame_kind kind;
        first = bytes_sent;
        while (bytes_sent - first < goal) begin
            pick = $urandom_range(99);
            kind = FRAME_GOOD;
            if (pick >= 70 && pick < 77)
                kind = FRAME_BAD_SUM;
            else if (pick >= 77 && pick < 82 && cfg_shadow.max_node_id != 8'hFF)
                kind = FRAME_BAD_ID;
            else if (pick >= 82 && pick < 87)
                kind = FRAME_BAD_SIZE;
            else if (pick >= 87 && pick < 92)
                kind = FRAME_BAD_HEADER;
            else if (pick >= 92 && cfg_shadow.timeout_ticks <= 32)
                kind = FRAME_STALLED;
            send_frame(kind, 0);
            if ($urandom_range(99) < 5) wait_drained();
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: default header and id limit, short timeout
        set_config(16'hFFFF, 8'd253, 16'd2);
        // tick with no frame in progress is ignored
        send_tick();
        // empty frame: one ok result with no content
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h02); send_byte(8'h00); send_byte(8'hFD);
        // id one above the limit
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFE);
        // id at the limit, length below two
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFD); send_byte(8'h01);
        // length one above the size limit
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h01); send_byte(8'(SIZE_LIMIT + 1));
        // wrong second header byte drops back to hunting
        send_byte(8'hFF); send_byte(8'h00);
        // one content byte, checksum off by one
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h01);
        send_byte(8'h03); send_byte(8'h20); send_byte(8'h55); send_byte(8'h87);
        // header byte then ticks up to the timeout
        send_byte(8'hFF); send_tick(); send_tick();

        // random header, result side stalls for a long stretch behind a full-size frame
        set_config(16'($urandom_range(16'hFFFF)), 8'd253, 16'd6);
        hold_off_req = 1'b1;
        send_frame(FRAME_GOOD, SIZE_LIMIT);
        run_frames(15);

        // all-zero header, only id zero allowed, any tick after a header byte times out
        set_config(16'h0000, 8'd0, 16'd1);
        run_frames(15);

        // every id allowed, timeout never reached; first part with no idling at all
        set_config(16'($urandom_range(16'hFFFF)), 8'hFF, 16'hFFFF);
        sender_idles = 1'b0;
        ready_idles  = 1'b0;
        send_frame(FRAME_GOOD, SIZE_LIMIT);
        run_frames(20);
        sender_idles = 1'b1;
        ready_idles  = 1'b1;
        run_frames(10);

        set_config(16'($urandom_range(16'hFFFF)), 8'($urandom_range(1, 254)),
                   16'($urandom_range(2, 12)));
        run_frames(15);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due == 0)
            $display("** servo_frame_receiver_core: PASSED **");
        else
            $display("** servo_frame_receiver_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sfr_pkg.sv
rtl/core/sfr_content_ram.sv
rtl/core/sfr_parser.sv
rtl/core/sfr_emitter.sv
rtl/core/servo_frame_receiver_core.sv
sim/servo_frame_receiver_checker.sv
sim/tb_top.sv
